>>> sv/hrsp_pkg.sv
// Package for the HTTP request segment parser: constants, result type, helper functions.
`default_nettype none

package hrsp_pkg;

   localparam int HRSP_POS_BITS = 16;
   localparam int HRSP_LEN_BITS = 32;

   localparam logic [15:0] HRSP_SEG_SAT = 16'hFFFF;
   localparam logic [15:0] HRSP_KEY_LEN = 16'd14;

   // event kinds
   localparam logic [2:0] KIND_METHOD  = 3'd0;
   localparam logic [2:0] KIND_URI     = 3'd1;
   localparam logic [2:0] KIND_VERSION = 3'd2;
   localparam logic [2:0] KIND_HEADER  = 3'd3;
   localparam logic [2:0] KIND_BODY    = 3'd4;

   // characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [15:0] seg_start;
      logic [15:0] seg_length;
      logic [15:0] value_start;
      logic [15:0] value_length;
      logic        is_length_header;
      logic [31:0] body_length;
   } hrsp_result_type;

   function automatic logic is_printable(input logic [7:0] c);
      return (c >= 8'h20) && (c <= 8'h7E);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v != HRSP_SEG_SAT) ? v + 16'd1 : v;
   endfunction

   // "content-length", lower case
   function automatic logic [7:0] key_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:  ch = 8'h63; // c
         4'd1:  ch = 8'h6F; // o
         4'd2:  ch = 8'h6E; // n
         4'd3:  ch = 8'h74; // t
         4'd4:  ch = 8'h65; // e
         4'd5:  ch = 8'h6E; // n
         4'd6:  ch = 8'h74; // t
         4'd7:  ch = 8'h2D; // -
         4'd8:  ch = 8'h6C; // l
         4'd9:  ch = 8'h65; // e
         4'd10: ch = 8'h6E; // n
         4'd11: ch = 8'h67; // g
         4'd12: ch = 8'h74; // t
         4'd13: ch = 8'h68; // h
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

>>> sv/hrsp_if.sv
// Valid/ready channel interfaces for request bytes and parse events.
`default_nettype none

interface hrsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;

   modport source (output valid, output byte_value, input ready);
   modport sink   (input valid, input byte_value, output ready);
endinterface

interface hrsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [15:0] seg_start;
   logic [15:0] seg_length;
   logic [15:0] value_start;
   logic [15:0] value_length;
   logic        is_length_header;
   logic [31:0] body_length;

   modport source (output valid, output event_kind, output seg_start, output seg_length,
                   output value_start, output value_length, output is_length_header,
                   output body_length, input ready);
   modport sink   (input valid, input event_kind, input seg_start, input seg_length,
                   input value_start, input value_length, input is_length_header,
                   input body_length, output ready);
endinterface

`default_nettype wire

>>> sv/http_request_segment_parser.sv
// Top level of the HTTP request segment parser: input register, parser core, result register.
`default_nettype none

// Channel   Direction  Payload                                            Transaction
// req_ch    in         byte_value[7:0]                                    one stream byte
// rsp_ch    out        event_kind, seg_start, seg_length, value_start,    one segment event
//                      value_length, is_length_header, body_length
//
// One byte per cycle sustained while rsp_ch is not stalled. A byte is held in the input register,
// and its event (if any) is loaded into the result register when the byte advances.
// The per-byte state update (including the times-ten add of the length parser) fits
// between the two registers, so the parser loop sets no limit below one byte per cycle.
// Synchronous active-high reset returns the parser to idle with position zero.
// A stalled result holds the input register, and a full input register holds req_ch.

module http_request_segment_parser
   import hrsp_pkg::*;
#(
   parameter int POS_BITS = HRSP_POS_BITS,
   parameter int LEN_BITS = HRSP_LEN_BITS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hrsp_req_if.sink   req_ch,
   hrsp_rsp_if.source rsp_ch
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            out_free;
   logic            advance;
   logic            has_result;
   hrsp_result_type result;

   // advance the held byte whenever the result register can take its outcome
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // capture the byte on every accepted transaction
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.byte_value;
      end
   end

   hrsp_parse_core #(
      .POS_BITS (POS_BITS),
      .LEN_BITS (LEN_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .byte_value (in_byte_ff),
      .has_result (has_result),
      .result     (result)
   );

   hrsp_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (has_result),
      .result     (result),
      .free       (out_free),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

>>> sv/hrsp_parse_core.sv
// Parser state registers and the per-byte next-state and event logic.
`default_nettype none

module hrsp_parse_core
   import hrsp_pkg::*;
#(
   parameter int POS_BITS = HRSP_POS_BITS,
   parameter int LEN_BITS = HRSP_LEN_BITS
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step_en,
   input  wire logic [7:0]      byte_value,
   output logic                 has_result,
   output hrsp_result_type      result
);

   localparam logic [3:0] ST_INITIAL     = 4'd0;
   localparam logic [3:0] ST_METHOD      = 4'd1;
   localparam logic [3:0] ST_METHOD_END  = 4'd2;
   localparam logic [3:0] ST_URI         = 4'd3;
   localparam logic [3:0] ST_URI_END     = 4'd4;
   localparam logic [3:0] ST_VERSION     = 4'd5;
   localparam logic [3:0] ST_VERSION_END = 4'd6;
   localparam logic [3:0] ST_KEY         = 4'd7;
   localparam logic [3:0] ST_VALUE       = 4'd8;
   localparam logic [3:0] ST_VALUE_END   = 4'd9;
   localparam logic [3:0] ST_BODY        = 4'd10;

   localparam logic [1:0] PH_SKIP  = 2'd0;
   localparam logic [1:0] PH_DIGIT = 2'd1;
   localparam logic [1:0] PH_NEG   = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   localparam logic [LEN_BITS-1:0] LEN_SEG_SAT = LEN_BITS'(HRSP_SEG_SAT);

   logic [3:0]          state_ff, state_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [POS_BITS-1:0] seg_begin_ff, seg_begin_in;
   logic [15:0]         seg_count_ff, seg_count_in;
   logic [POS_BITS-1:0] val_begin_ff, val_begin_in;
   logic [15:0]         val_count_ff, val_count_in;
   logic                val_seen_ff, val_seen_in;
   logic                key_match_ff, key_match_in;
   logic [1:0]          phase_ff, phase_in;
   logic [LEN_BITS-1:0] accum_ff, accum_in;
   logic [LEN_BITS-1:0] content_len_ff, content_len_in;
   logic [LEN_BITS-1:0] body_count_ff, body_count_in;

   logic [LEN_BITS+3:0] accum_prod;
   logic [LEN_BITS-1:0] accum_next;
   logic [LEN_BITS-1:0] body_count_nx;
   logic [POS_BITS-1:0] body_begin;
   logic                val_seen_now;
   logic                key_hit;
   logic                white;

   // accum * 10 + digit, saturating
   assign accum_prod = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1)
                       + (LEN_BITS + 4)'(byte_value[3:0]);
   assign accum_next = (accum_prod[LEN_BITS+3:LEN_BITS] != 4'd0) ? '1
                                                                  : accum_prod[LEN_BITS-1:0];

   assign body_count_nx = body_count_ff + LEN_BITS'(1);
   assign body_begin    = (body_count_ff == '0) ? pos_ff : seg_begin_ff;
   assign val_seen_now  = val_seen_ff || is_printable(byte_value);
   assign key_hit       = key_match_ff && (seg_count_ff == HRSP_KEY_LEN);
   assign white         = (byte_value == CH_SPACE) || (byte_value == CH_TAB)
                          || (byte_value == CH_VT) || (byte_value == CH_FF)
                          || (byte_value == CH_CR);

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff + POS_BITS'(1);
      seg_begin_in   = seg_begin_ff;
      seg_count_in   = seg_count_ff;
      val_begin_in   = val_begin_ff;
      val_count_in   = val_count_ff;
      val_seen_in    = val_seen_ff;
      key_match_in   = key_match_ff;
      phase_in       = phase_ff;
      accum_in       = accum_ff;
      content_len_in = content_len_ff;
      body_count_in  = body_count_ff;
      has_result     = 1'b0;
      result         = '0;

      case (state_ff)
         ST_METHOD, ST_URI: begin
            if (byte_value == CH_SPACE) begin
               has_result        = 1'b1;
               result.event_kind = (state_ff == ST_METHOD) ? KIND_METHOD : KIND_URI;
               result.seg_start  = 16'(seg_begin_ff);
               result.seg_length = seg_count_ff;
               state_in = (state_ff == ST_METHOD) ? ST_METHOD_END : ST_URI_END;
            end else begin
               seg_count_in = sat_inc(seg_count_ff);
            end
         end
         ST_METHOD_END, ST_URI_END: begin
            if (is_printable(byte_value)) begin
               seg_begin_in = pos_ff;
               seg_count_in = 16'd1;
               state_in = (state_ff == ST_METHOD_END) ? ST_URI : ST_VERSION;
            end
         end
         ST_VERSION: begin
            if (byte_value == CH_LF) begin
               has_result        = 1'b1;
               result.event_kind = KIND_VERSION;
               result.seg_start  = 16'(seg_begin_ff);
               result.seg_length = seg_count_ff;
               state_in          = ST_VERSION_END;
            end else if (is_printable(byte_value)) begin
               seg_count_in = sat_inc(seg_count_ff);
            end
         end
         ST_KEY: begin
            if (byte_value == CH_COLON) begin
               val_begin_in = '0;
               val_count_in = '0;
               val_seen_in  = 1'b0;
               phase_in     = PH_SKIP;
               accum_in     = '0;
               state_in     = ST_VALUE;
            end else begin
               if ((seg_count_ff >= HRSP_KEY_LEN)
                   || (to_lower(byte_value) != key_char(seg_count_ff[3:0]))) begin
                  key_match_in = 1'b0;
               end
               seg_count_in = sat_inc(seg_count_ff);
            end
         end
         ST_VALUE: begin
            if (byte_value == CH_LF) begin
               // the accumulator is zero for a missing value or a negative sign
               if (key_hit) begin
                  content_len_in = accum_ff;
               end
               has_result              = 1'b1;
               result.event_kind       = KIND_HEADER;
               result.seg_start        = 16'(seg_begin_ff);
               result.seg_length       = seg_count_ff;
               result.value_start      = val_seen_ff ? 16'(val_begin_ff) : 16'd0;
               result.value_length     = val_count_ff;
               result.is_length_header = key_hit;
               result.body_length      = 32'(key_hit ? accum_ff : content_len_ff);
               seg_begin_in = '0;
               seg_count_in = '0;
               val_begin_in = '0;
               val_count_in = '0;
               val_seen_in  = 1'b0;
               state_in     = ST_VALUE_END;
            end else begin
               if (is_printable(byte_value)) begin
                  if (!val_seen_ff) begin
                     val_begin_in = pos_ff;
                     val_seen_in  = 1'b1;
                  end
                  val_count_in = sat_inc(val_count_ff);
               end
               if (val_seen_now) begin
                  case (phase_ff)
                     PH_NEG: begin
                        accum_in = '0;
                        if (!is_digit(byte_value)) begin
                           phase_in = PH_DONE;
                        end
                     end
                     PH_SKIP: begin
                        if (white) begin
                           phase_in = PH_SKIP;
                        end else if (byte_value == CH_PLUS) begin
                           phase_in = PH_DIGIT;
                        end else if (byte_value == CH_MINUS) begin
                           phase_in = PH_NEG;
                        end else if (is_digit(byte_value)) begin
                           phase_in = PH_DIGIT;
                           accum_in = accum_next;
                        end else begin
                           phase_in = PH_DONE;
                        end
                     end
                     PH_DIGIT: begin
                        if (is_digit(byte_value)) begin
                           accum_in = accum_next;
                        end else begin
                           phase_in = PH_DONE;
                        end
                     end
                     default: begin
                        phase_in = PH_DONE;
                     end
                  endcase
               end
            end
         end
         ST_VERSION_END, ST_VALUE_END: begin
            if ((state_ff == ST_VALUE_END) && (byte_value == CH_LF)) begin
               if (content_len_ff == '0) begin
                  has_result        = 1'b1;
                  result.event_kind = KIND_BODY;
                  state_in          = ST_INITIAL;
               end else begin
                  body_count_in = '0;
                  state_in      = ST_BODY;
               end
            end else if (is_printable(byte_value)) begin
               seg_begin_in = pos_ff;
               seg_count_in = 16'd1;
               key_match_in = (to_lower(byte_value) == key_char(4'd0));
               state_in     = ST_KEY;
            end
         end
         ST_BODY: begin
            if (body_count_nx >= content_len_ff) begin
               has_result         = 1'b1;
               result.event_kind  = KIND_BODY;
               result.seg_start   = 16'(body_begin);
               result.seg_length  = (content_len_ff > LEN_SEG_SAT) ? HRSP_SEG_SAT
                                                                   : content_len_ff[15:0];
               result.body_length = 32'(content_len_ff);
               seg_begin_in  = '0;
               seg_count_in  = '0;
               body_count_in = '0;
               state_in      = ST_INITIAL;
            end else begin
               seg_begin_in  = body_begin;
               body_count_in = body_count_nx;
            end
         end
         default: begin
            // idle and unused codes: wait for a letter to open a request
            if (is_letter(byte_value)) begin
               seg_begin_in   = pos_ff;
               seg_count_in   = 16'd1;
               content_len_in = '0;
               state_in       = ST_METHOD;
            end else begin
               state_in = ST_INITIAL;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INITIAL;
         pos_ff         <= '0;
         seg_begin_ff   <= '0;
         seg_count_ff   <= '0;
         val_begin_ff   <= '0;
         val_count_ff   <= '0;
         val_seen_ff    <= 1'b0;
         key_match_ff   <= 1'b1;
         phase_ff       <= PH_SKIP;
         accum_ff       <= '0;
         content_len_ff <= '0;
         body_count_ff  <= '0;
      end else if (step_en) begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         seg_begin_ff   <= seg_begin_in;
         seg_count_ff   <= seg_count_in;
         val_begin_ff   <= val_begin_in;
         val_count_ff   <= val_count_in;
         val_seen_ff    <= val_seen_in;
         key_match_ff   <= key_match_in;
         phase_ff       <= phase_in;
         accum_ff       <= accum_in;
         content_len_ff <= content_len_in;
         body_count_ff  <= body_count_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/hrsp_out_reg.sv
// Result register that drives the event channel.
`default_nettype none

module hrsp_out_reg
   import hrsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire logic        load_valid,
   input  hrsp_result_type  result,
   output logic             free,
   hrsp_rsp_if.source       rsp_ch
);

   logic            valid_ff, valid_in;
   hrsp_result_type data_ff;

   assign free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = load_valid;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         data_ff <= result;
      end
   end

   assign rsp_ch.valid            = valid_ff;
   assign rsp_ch.event_kind       = data_ff.event_kind;
   assign rsp_ch.seg_start        = data_ff.seg_start;
   assign rsp_ch.seg_length       = data_ff.seg_length;
   assign rsp_ch.value_start      = data_ff.value_start;
   assign rsp_ch.value_length     = data_ff.value_length;
   assign rsp_ch.is_length_header = data_ff.is_length_header;
   assign rsp_ch.body_length      = data_ff.body_length;

endmodule

`default_nettype wire
